// ----- src/sirt_pkg.sv -----
// Shared types, constants and the alphabet check for the radix text converter.
`timescale 1ns / 1ps

package sirt_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_CHARS = 16;
    localparam int ALPHA_W     = ALPHA_CHARS * CHAR_W;
    localparam int DIV_STEP    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX_SIZE = 2'd2;

    localparam logic [CHAR_W-1:0] SIGN_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR = 8'h2B;

    typedef struct packed {
        logic [ALPHA_W-1:0] alphabet;
        logic [RADIX_W-1:0] radix_size;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIVIDE,
        ST_EMIT
    } back_state_t;

    function automatic logic alphabet_ok(
        input logic [ALPHA_W-1:0] alpha,
        input logic [RADIX_W-1:0] n,
        input logic [RADIX_W-1:0] max_r
    );
        logic ok;
        logic [CHAR_W-1:0] ci;
        ok = 1'b1;
        if (n < RADIX_W'(2) || n > max_r)
            ok = 1'b0;
        for (int i = 0; i < ALPHA_CHARS; i++)
        begin
            ci = alpha[i*CHAR_W +: CHAR_W];
            if (RADIX_W'(i) < n)
            begin
                if (ci == PLUS_CHAR || ci == SIGN_CHAR)
                    ok = 1'b0;
                for (int j = i + 1; j < ALPHA_CHARS; j++)
                begin
                    if (RADIX_W'(j) < n && alpha[j*CHAR_W +: CHAR_W] == ci)
                        ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

// ----- src/sirt_queue.sv -----
// Two-entry queue between the front and the back part.
`timescale 1ns / 1ps

module sirt_queue
    import sirt_pkg::*;
#(
    parameter int WIDTH = 33
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/sirt_front.sv -----
// Front part: configuration registers, alphabet check, sign split of each item.
`timescale 1ns / 1ps

module sirt_front
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX   = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] number,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [VALUE_WIDTH:0]          q_data,
    output cfg_t                          cfg
);

    logic [CFG_DATA_W-1:0] alpha_low_reg, alpha_low_next;
    logic [CFG_DATA_W-1:0] alpha_high_reg, alpha_high_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic                   valid_alpha;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        alpha_low_next  = alpha_low_reg;
        alpha_high_next = alpha_high_reg;
        radix_next      = radix_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALPHA_LOW:  alpha_low_next  = cfg_data;
                REG_ALPHA_HIGH: alpha_high_next = cfg_data;
                REG_RADIX_SIZE: radix_next      = cfg_data[RADIX_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            radix_reg      <= '0;
        end
        else
        begin
            alpha_low_reg  <= alpha_low_next;
            alpha_high_reg <= alpha_high_next;
            radix_reg      <= radix_next;
        end
    end

    assign cfg.alphabet   = {alpha_high_reg, alpha_low_reg};
    assign cfg.radix_size = radix_reg;

    assign valid_alpha = alphabet_ok({alpha_high_reg, alpha_low_reg}, radix_reg,
                                     RADIX_W'(MAX_RADIX));

    // Drop items when the alphabet is unusable.
    assign raw      = number;
    assign neg      = raw[VALUE_WIDTH-1];
    assign mag      = neg ? (VALUE_WIDTH'(0) - raw) : raw;
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && valid_alpha;
    assign q_data   = {neg, mag};

endmodule

// ----- src/sirt_back.sv -----
// Back part: digit division, digit stack and character output register.
`timescale 1ns / 1ps

module sirt_back
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX   = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  logic [VALUE_WIDTH:0] q_data,
    output logic                 q_pop,
    input  cfg_t                 cfg,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CHAR_W-1:0]    text_char,
    output logic                 last
);

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int REM_W   = DIGIT_W + 1;
    localparam int PAD_W   = ((VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int STEPS   = PAD_W / DIV_STEP;
    localparam int CNT_W   = $clog2(STEPS);
    localparam int SP_W    = $clog2(VALUE_WIDTH + 1);

    back_state_t state_reg, state_next;

    logic [PAD_W-1:0]   quot_reg, quot_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIGIT_W-1:0] stack_reg [VALUE_WIDTH];
    logic [DIGIT_W-1:0] stack_next [VALUE_WIDTH];
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic [REM_W-1:0]   radix;
    logic [REM_W-1:0]   r_step;
    logic [PAD_W-1:0]   q_step;
    logic               div_final;
    logic               slot_free;
    logic [3:0]         top_idx;

    assign radix     = cfg.radix_size[REM_W-1:0];
    assign slot_free = !out_valid_reg || !out_stall;
    assign div_final = (cnt_reg == CNT_W'(STEPS - 1));
    assign top_idx   = 4'(stack_reg[0]);

    always_comb
    begin
        r_step = rem_reg;
        q_step = quot_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            r_step = {r_step[REM_W-2:0], q_step[PAD_W-1]};
            q_step = {q_step[PAD_W-2:0], 1'b0};
            if (r_step >= radix)
            begin
                r_step    = r_step - radix;
                q_step[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (!q_empty)
                    state_next = q_data[VALUE_WIDTH] ? ST_SIGN : ST_DIVIDE;
            ST_SIGN:
                if (slot_free)
                    state_next = ST_DIVIDE;
            ST_DIVIDE:
                if (div_final && q_step == '0)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (slot_free && sp_reg == SP_W'(1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        stack_next     = stack_reg;
        sp_next        = sp_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    quot_next = PAD_W'(q_data[VALUE_WIDTH-1:0]);
                    rem_next  = '0;
                    cnt_next  = '0;
                    sp_next   = '0;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = SIGN_CHAR;
                    last_next      = 1'b0;
                end
            end
            ST_DIVIDE:
            begin
                quot_next = q_step;
                rem_next  = r_step;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (div_final)
                begin
                    // Push digit, restart on the quotient.
                    stack_next[0] = r_step[DIGIT_W-1:0];
                    for (int i = 1; i < VALUE_WIDTH; i++)
                        stack_next[i] = stack_reg[i-1];
                    sp_next  = sp_reg + SP_W'(1);
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = cfg.alphabet[top_idx*CHAR_W +: CHAR_W];
                    last_next      = (sp_reg == SP_W'(1));
                    for (int i = 0; i < VALUE_WIDTH - 1; i++)
                        stack_next[i] = stack_reg[i+1];
                    sp_next = sp_reg - SP_W'(1);
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        stack_reg <= stack_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last      = last_reg;

endmodule

// ----- src/signed_integer_to_radix_text.sv -----
// Top level of the signed integer to radix text converter.
`timescale 1ns / 1ps

// Converts each signed number on the input channel to text in the radix given by the
// configured alphabet (radix = radix_size, 2..MAX_RADIX, no '+' or '-', no repeats),
// one character per output item, most significant first, with last on the final
// character; a negative number starts with '-'. Items taken while the alphabet is
// invalid produce no output. The front part takes items into a two-entry queue; the
// back part handles one item at a time. A shared divider takes four quotient bits per
// cycle; each digit is the remainder of one full pass over the padded value, and the
// passes go on with the quotient until it is zero. The user must see to it that
// configuration is written only while the block is idle; the block does not enforce this.

module signed_integer_to_radix_text
    import sirt_pkg::*;
#(
    parameter int MAX_RADIX   = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [CHAR_W-1:0]             text_char,
    output logic                          last
);

    cfg_t                 cfg;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic [VALUE_WIDTH:0] q_in_data;
    logic [VALUE_WIDTH:0] q_out_data;

    sirt_front #(
        .MAX_RADIX   (MAX_RADIX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .number    (number),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in_data),
        .cfg       (cfg)
    );

    sirt_queue #(
        .WIDTH (VALUE_WIDTH + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out_data),
        .empty     (q_empty)
    );

    sirt_back #(
        .MAX_RADIX   (MAX_RADIX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_out_data),
        .q_pop     (q_pop),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last      (last)
    );

endmodule
